>>> rtl/core/assert_macros.svh
// Assertion macros shared by the queue and back-end modules of the mono downmix unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ON(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_ON(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> rtl/core/pcmq_pkg.sv
// Package with the types and constants of the mono downmix unit.
package pcmq_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int RAW_W        = 32;
    localparam int SAMPLE_W     = 16;
    localparam int POS_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
    localparam int SUM_W        = SAMPLE_W + $clog2(MAX_CHANNELS) + 1;
    localparam int ITER_W       = $clog2(SUM_W + 1);
    localparam int FMT_W        = 2;
    localparam int CHAN_W       = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 4;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;
    localparam int Q15_MAX      = 32767;
    localparam int Q15_MIN      = -32768;

    typedef enum logic [FMT_W-1:0] {
        FMT_U8  = 2'd0,
        FMT_S16 = 2'd1,
        FMT_S24 = 2'd2,
        FMT_S32 = 2'd3
    } t_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_FORMAT = 1'b0,
        REG_CHANNEL_COUNT = 1'b1
    } t_reg_idx;

    localparam t_fmt              FMT_RESET  = FMT_S16;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 4'd2;

    typedef struct packed {
        logic [RAW_W-1:0] raw_sample;
        logic             last_in_clip;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mono_sample;
        logic                       last_out;
    } t_out;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
        logic                    last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> rtl/core/pcmq_front.sv
// Front end: configuration registers, sample conversion and frame accumulation.
module pcmq_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  pcmq_pkg::t_in                      i_in,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pcmq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pcmq_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  pcmq_pkg::t_q_status                i_q_status,
    output logic                               o_push,
    output pcmq_pkg::t_job                     o_job
);

    pcmq_pkg::t_fmt                          r_fmt;
    logic [pcmq_pkg::CHAN_W-1:0]             r_chan;
    logic [pcmq_pkg::POS_W-1:0]              r_pos, n_pos;
    logic signed [pcmq_pkg::SUM_W-1:0]       r_sum, n_sum;

    logic [pcmq_pkg::CNT_W-1:0]              w_count;
    logic signed [pcmq_pkg::SAMPLE_W-1:0]    w_conv;
    logic signed [pcmq_pkg::SUM_W-1:0]       w_sum_new;
    logic                                    w_accept;
    logic                                    w_done;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_status.full;
    assign w_accept    = i_in_valid && !i_q_status.full;

    always_comb begin
        if (r_chan == '0) begin
            w_count = pcmq_pkg::CNT_W'(1);
        end else if (int'(r_chan) > pcmq_pkg::MAX_CHANNELS) begin
            w_count = pcmq_pkg::CNT_W'(pcmq_pkg::MAX_CHANNELS);
        end else begin
            w_count = pcmq_pkg::CNT_W'(r_chan);
        end
    end

    always_comb begin
        unique case (r_fmt)
            pcmq_pkg::FMT_U8: begin
                w_conv = {~i_in.raw_sample[7], i_in.raw_sample[6:0], 8'h00};
            end
            pcmq_pkg::FMT_S16: begin
                w_conv = i_in.raw_sample[15:0];
            end
            pcmq_pkg::FMT_S24: begin
                w_conv = i_in.raw_sample[23:8];
            end
            pcmq_pkg::FMT_S32: begin
                w_conv = i_in.raw_sample[31:16];
            end
            default: begin
                w_conv = i_in.raw_sample[15:0];
            end
        endcase
    end

    assign w_sum_new = r_sum + pcmq_pkg::SUM_W'(w_conv);
    assign w_done    = (int'(r_pos) + 1) >= int'(w_count);

    assign o_push = w_accept && w_done;
    assign o_job  = '{sum: w_sum_new, count: w_count, last: i_in.last_in_clip};

    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        if (w_accept) begin
            if (w_done || i_in.last_in_clip) begin
                n_pos = '0;
                n_sum = '0;
            end else begin
                n_pos = r_pos + pcmq_pkg::POS_W'(1);
                n_sum = w_sum_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= pcmq_pkg::FMT_RESET;
            r_chan <= pcmq_pkg::CHAN_RESET;
            r_pos  <= '0;
            r_sum  <= '0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
            if (i_cfg_valid) begin
                if (i_cfg_index == pcmq_pkg::REG_SAMPLE_FORMAT) begin
                    r_fmt <= pcmq_pkg::t_fmt'(i_cfg_data[pcmq_pkg::FMT_W-1:0]);
                end else if (i_cfg_index == pcmq_pkg::REG_CHANNEL_COUNT) begin
                    r_chan <= i_cfg_data[pcmq_pkg::CHAN_W-1:0];
                end
            end
        end
    end

endmodule

>>> rtl/core/pcmq_queue.sv
// Two-entry queue that carries finished frame sums from the front to the back.
`include "assert_macros.svh"

module pcmq_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pcmq_pkg::t_job      i_job,
    input  logic                i_pop,
    output pcmq_pkg::t_job      o_job,
    output pcmq_pkg::t_q_status o_status
);

    pcmq_pkg::t_job                r_mem [pcmq_pkg::QDEPTH];
    logic [pcmq_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [pcmq_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [pcmq_pkg::QCNT_W-1:0]   r_count;

    assign o_job          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == pcmq_pkg::QCNT_W'(pcmq_pkg::QDEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + pcmq_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + pcmq_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + pcmq_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - pcmq_pkg::QCNT_W'(1);
            end
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_status.full)
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_status.empty)
    `ASSERT_ON(a_count_bound, i_clk, i_rst_n, r_count <= pcmq_pkg::QCNT_W'(pcmq_pkg::QDEPTH))

endmodule

>>> rtl/core/pcmq_back.sv
// Back end: serial divider by the channel count, clamp and output register.
`include "assert_macros.svh"

module pcmq_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcmq_pkg::t_q_status i_q_status,
    input  pcmq_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pcmq_pkg::t_out      o_out
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } t_bstate;

    t_bstate                              r_state;
    logic [pcmq_pkg::SUM_W-1:0]           r_mag;
    logic [pcmq_pkg::CNT_W-1:0]           r_rem;
    logic [pcmq_pkg::CNT_W-1:0]           r_div;
    logic                                 r_neg;
    logic                                 r_last;
    logic [pcmq_pkg::ITER_W-1:0]          r_iter;
    logic                                 r_out_valid;
    pcmq_pkg::t_out                       r_out;

    logic [pcmq_pkg::CNT_W:0]             w_trial;
    logic [pcmq_pkg::CNT_W:0]             w_sub;
    logic                                 w_qbit;
    logic                                 w_div_end;
    logic                                 w_out_free;
    logic                                 w_write;
    logic signed [pcmq_pkg::SUM_W:0]      w_quot;
    logic signed [pcmq_pkg::SAMPLE_W-1:0] w_clamped;

    assign o_pop       = (r_state == S_IDLE) && !i_q_status.empty;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_trial    = {r_rem, r_mag[pcmq_pkg::SUM_W-1]};
    assign w_sub      = w_trial - {1'b0, r_div};
    assign w_qbit     = (w_trial >= {1'b0, r_div});
    assign w_div_end  = (r_iter == pcmq_pkg::ITER_W'(pcmq_pkg::SUM_W));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_write    = (r_state == S_DIV) && w_div_end && w_out_free;

    always_comb begin
        if (r_neg) begin
            w_quot = -$signed({1'b0, r_mag});
        end else begin
            w_quot = $signed({1'b0, r_mag});
        end
        if (w_quot > (pcmq_pkg::SUM_W+1)'(pcmq_pkg::Q15_MAX)) begin
            w_clamped = pcmq_pkg::SAMPLE_W'(pcmq_pkg::Q15_MAX);
        end else if (w_quot < (pcmq_pkg::SUM_W+1)'(pcmq_pkg::Q15_MIN)) begin
            w_clamped = pcmq_pkg::SAMPLE_W'(pcmq_pkg::Q15_MIN);
        end else begin
            w_clamped = w_quot[pcmq_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_neg  <= i_job.sum[pcmq_pkg::SUM_W-1];
            r_mag  <= i_job.sum[pcmq_pkg::SUM_W-1] ? -i_job.sum : i_job.sum;
            r_rem  <= '0;
            r_div  <= i_job.count;
            r_last <= i_job.last;
        end else if ((r_state == S_DIV) && !w_div_end) begin
            r_mag <= {r_mag[pcmq_pkg::SUM_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_sub[pcmq_pkg::CNT_W-1:0] : w_trial[pcmq_pkg::CNT_W-1:0];
        end
        if (w_write) begin
            r_out <= '{mono_sample: w_clamped, last_out: r_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_DIV;
                        r_iter  <= '0;
                    end
                end
                S_DIV: begin
                    if (!w_div_end) begin
                        r_iter <= r_iter + pcmq_pkg::ITER_W'(1);
                    end else if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_write) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `ASSERT_ON(a_div_nonzero, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_div != '0))
    `ASSERT_ON(a_iter_bound, i_clk, i_rst_n, r_iter <= pcmq_pkg::ITER_W'(pcmq_pkg::SUM_W))
    `ASSERT_ON(a_pop_starts, i_clk, i_rst_n, o_pop |=> (r_state == S_DIV))

endmodule

>>> rtl/core/pcm_to_q15_mono_downmix_unit.sv
// Top level of the PCM to Q15 mono downmix unit.
//
//  Channel   Direction  Handshake             Payload
//  in        sink       i_in_valid/o_in_stall  pcmq_pkg::t_in (raw sample, clip end)
//  out       source     o_out_valid/i_out_stall pcmq_pkg::t_out (mono sample, last)
//  cfg       sink       i_cfg_valid/o_cfg_ready index and write data
//
// A channel sample is accepted whenever it is valid and the frame queue has room.
// A finished frame passes through the serial divider in the back end, which
// produces one quotient bit per cycle over the 20-bit frame sum.
// Reset is synchronous and sets 16-bit samples with two channels per frame.
// The input stalls only while the two-entry frame queue is full.
module pcm_to_q15_mono_downmix_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  pcmq_pkg::t_in                      i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output pcmq_pkg::t_out                     o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pcmq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pcmq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    pcmq_pkg::t_q_status w_q_status;
    pcmq_pkg::t_job      w_push_job;
    pcmq_pkg::t_job      w_pop_job;
    logic                w_push;
    logic                w_pop;

    pcmq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    pcmq_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_pop_job),
        .o_status (w_q_status)
    );

    pcmq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (w_q_status),
        .i_job       (w_pop_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
